// ===== rtl/core/heq_pkg.sv =====
// heq_pkg: shared constants, action and address codes, controller/datapath structs
// for the histogram equalization unit. No dependencies.

package heq_pkg;

	// pixel and bin geometry
	localparam int PIX_W    = 8;
	localparam int ACT_W    = 2;
	localparam int NUM_BINS = 256;
	localparam int BIN_W    = 21;

	// frame limit; bins and the pixel total saturate here
	localparam logic [BIN_W-1:0] MAX_PIXELS = 21'd1048576;

	// divider geometry: numerator is cdf * 255, remainder one bit wider than divisor
	localparam int NUM_W  = BIN_W + 8;
	localparam int REM_W  = BIN_W + 1;
	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] LAST_STEP = 5'(NUM_W - 1);

	localparam logic [PIX_W-1:0] OUT_MAX = 8'd255;

	// actions of an input beat
	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
	localparam logic [ACT_W-1:0] ACT_COUNT = 2'd1;
	localparam logic [ACT_W-1:0] ACT_BUILD = 2'd2;
	localparam logic [ACT_W-1:0] ACT_MAP   = 2'd3;

	// bin memory address source
	localparam logic [1:0] ADDR_IN  = 2'd0;
	localparam logic [1:0] ADDR_PIX = 2'd1;
	localparam logic [1:0] ADDR_IDX = 2'd2;

	typedef struct packed {
		logic       rd_en;
		logic       wr_en;
		logic       wr_acc;
		logic [1:0] addr_sel;
		logic       pix_load;
		logic       clear;
		logic       total_inc;
		logic       acc_clr;
		logic       acc_load;
		logic       idx_clr;
		logic       idx_inc;
		logic       div_start;
		logic       out_load;
		logic       out_zero;
	} heq_cmd_t;

	typedef struct packed {
		logic total_full;
		logic total_zero;
		logic idx_last;
		logic div_busy;
		logic out_free;
	} heq_stat_t;

endpackage

// ===== rtl/core/histogram_equalization_unit.sv =====
// histogram_equalization_unit: top level, joins controller and datapath.
// Depends on heq_pkg, heq_ctrl, heq_dp.

// Global histogram equalization of 8-bit grayscale frames. Each input beat
// carries an action: clear empties all 256 bins and the pixel total; count
// (a bin read, then an incremented write) adds the pixel to its bin until the
// frame limit is reached, after which counts change nothing; build (a read and
// a write per bin over the 256-bin memory) turns the bins into cumulative
// counts in place; map emits one result beat round(cdf[pixel] * 255 / total),
// ties to even, saturated to 255, or 0 for an empty histogram. Map reads the
// bin, runs the 29-step bit-serial divider (skipped for an empty histogram)
// and waits while an earlier result beat is still stalled.
// One beat is processed at a time; the result register lets the next beat be
// taken while a result waits downstream. No clearing pass is needed after
// reset.

module histogram_equalization_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic [heq_pkg::ACT_W-1:0]   action,
	input  logic [heq_pkg::PIX_W-1:0]   pixel,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [heq_pkg::PIX_W-1:0]   out_pixel
);

	heq_pkg::heq_cmd_t  cmd;
	heq_pkg::heq_stat_t stat;

	heq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.action     (action),
		.item_stall (item_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	heq_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel        (pixel),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_pixel    (out_pixel)
	);

endmodule

// ===== rtl/core/heq_ram.sv =====
// heq_ram: generic single write port, single read port RAM with registered read.
// No dependencies.

module heq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/heq_div.sv =====
// heq_div: restoring divider, one quotient bit per cycle, with round-half-even
// and saturation of the quotient to 8 bits. Depends on heq_pkg.

module heq_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [heq_pkg::NUM_W-1:0]     num,
	input  logic [heq_pkg::BIN_W-1:0]     den,
	output logic                          busy,
	output logic [heq_pkg::PIX_W-1:0]     res
);

	logic                           busy_q;
	logic [heq_pkg::STEP_W-1:0]     step_q;
	logic [heq_pkg::REM_W-1:0]      rem_q;
	logic [heq_pkg::NUM_W-1:0]      quo_q;
	logic [heq_pkg::BIN_W-1:0]      den_q;
	logic [heq_pkg::REM_W-1:0]      trial;
	logic                           fits;
	logic [heq_pkg::REM_W:0]        rem2;
	logic                           rnd;
	logic [heq_pkg::NUM_W:0]        quo_rnd;

	// one restoring step: shift in next numerator bit, try subtract
	assign trial = {rem_q[heq_pkg::REM_W-2:0], quo_q[heq_pkg::NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == heq_pkg::LAST_STEP) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
			quo_q <= {quo_q[heq_pkg::NUM_W-2:0], fits};
		end
	end

	// round to nearest, ties to even, then saturate
	assign rem2    = {rem_q, 1'b0};
	assign rnd     = (rem2 > {2'b00, den_q}) || ((rem2 == {2'b00, den_q}) && quo_q[0]);
	assign quo_rnd = {1'b0, quo_q} + {{heq_pkg::NUM_W{1'b0}}, rnd};
	assign res     = (quo_rnd > {{(heq_pkg::NUM_W + 1 - heq_pkg::PIX_W){1'b0}}, heq_pkg::OUT_MAX})
		? heq_pkg::OUT_MAX : quo_rnd[heq_pkg::PIX_W-1:0];
	assign busy    = busy_q;

endmodule

// ===== rtl/core/heq_dp.sv =====
// heq_dp: datapath with bin memory and its valid bits, pixel total, cumulative
// accumulator, bin index, divider and output register. Depends on heq_pkg,
// heq_ram, heq_div.

module heq_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [heq_pkg::PIX_W-1:0]   pixel,
	input  heq_pkg::heq_cmd_t           cmd,
	output heq_pkg::heq_stat_t          stat,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [heq_pkg::PIX_W-1:0]   out_pixel
);

	logic [heq_pkg::PIX_W-1:0]    pix_q;
	logic [heq_pkg::PIX_W-1:0]    idx_q;
	logic [heq_pkg::PIX_W-1:0]    addr;
	logic [heq_pkg::BIN_W-1:0]    total_q;
	logic [heq_pkg::BIN_W-1:0]    acc_q;
	logic [heq_pkg::NUM_BINS-1:0] vld_q;
	logic                         rd_vld_q;
	logic [heq_pkg::BIN_W-1:0]    rd_data;
	logic [heq_pkg::BIN_W-1:0]    rd_cur;
	logic [heq_pkg::BIN_W:0]      inc_sum;
	logic [heq_pkg::BIN_W:0]      acc_sum;
	logic [heq_pkg::BIN_W-1:0]    inc_sat;
	logic [heq_pkg::BIN_W-1:0]    acc_sat;
	logic [heq_pkg::BIN_W-1:0]    wdata;
	logic [heq_pkg::NUM_W-1:0]    num;
	logic                         div_busy;
	logic [heq_pkg::PIX_W-1:0]    div_res;
	logic                         out_valid_q;
	logic [heq_pkg::PIX_W-1:0]    out_pixel_q;
	logic                         out_free;

	// bin address select, shared by read and write
	always_comb begin
		case (cmd.addr_sel)
			heq_pkg::ADDR_IN:  addr = pixel;
			heq_pkg::ADDR_PIX: addr = pix_q;
			heq_pkg::ADDR_IDX: addr = idx_q;
			default:           addr = pix_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.pix_load) begin
			pix_q <= pixel;
		end
	end

	// bin index for the cumulative sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// pixel total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cmd.clear) begin
			total_q <= '0;
		end else if (cmd.total_inc) begin
			total_q <= total_q + 1'b1;
		end
	end

	// bin valid bits: a bin never written since clear reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				vld_q <= '0;
			end else if (cmd.wr_en) begin
				vld_q[addr] <= 1'b1;
			end
			if (cmd.rd_en) begin
				rd_vld_q <= vld_q[addr];
			end
		end
	end

	heq_ram #(
		.WIDTH(heq_pkg::BIN_W),
		.DEPTH(heq_pkg::NUM_BINS)
	) u_bins (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (addr),
		.wdata (wdata),
		.re    (cmd.rd_en),
		.raddr (addr),
		.rdata (rd_data)
	);

	assign rd_cur = rd_vld_q ? rd_data : '0;

	// saturating bin increment and running sum
	assign inc_sum = {1'b0, rd_cur} + 1'b1;
	assign acc_sum = {1'b0, rd_cur} + {1'b0, acc_q};
	assign inc_sat = (inc_sum > {1'b0, heq_pkg::MAX_PIXELS}) ? heq_pkg::MAX_PIXELS
		: inc_sum[heq_pkg::BIN_W-1:0];
	assign acc_sat = (acc_sum > {1'b0, heq_pkg::MAX_PIXELS}) ? heq_pkg::MAX_PIXELS
		: acc_sum[heq_pkg::BIN_W-1:0];
	assign wdata   = cmd.wr_acc ? acc_sat : inc_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (cmd.acc_load) begin
			acc_q <= acc_sat;
		end
	end

	// cdf * 255 as a shift and subtract
	assign num = {rd_cur, 8'b0} - {8'b0, rd_cur};

	heq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num),
		.den    (total_q),
		.busy   (div_busy),
		.res    (div_res)
	);

	// output register
	assign out_free = !out_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_pixel_q <= cmd.out_zero ? '0 : div_res;
		end
	end

	assign result_valid    = out_valid_q;
	assign out_pixel       = out_pixel_q;
	assign stat.total_full = total_q >= heq_pkg::MAX_PIXELS;
	assign stat.total_zero = total_q == '0;
	assign stat.idx_last   = idx_q == 8'(heq_pkg::NUM_BINS - 1);
	assign stat.div_busy   = div_busy;
	assign stat.out_free   = out_free;

`ifndef ASSERT_OFF
	a_total_limit: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= heq_pkg::MAX_PIXELS)
		else $error("pixel total above frame limit");
	a_acc_limit: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q <= heq_pkg::MAX_PIXELS)
		else $error("cumulative sum above frame limit");
	a_clear_total: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (total_q == '0) && (vld_q == '0))
		else $error("clear did not empty the histogram");
`endif

endmodule

// ===== rtl/core/heq_ctrl.sv =====
// heq_ctrl: controller state machine; decodes input beats and sequences the
// count, cumulative sweep and map operations of the datapath. Depends on heq_pkg.

module heq_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	input  logic [heq_pkg::ACT_W-1:0]   action,
	output logic                        item_stall,
	input  heq_pkg::heq_stat_t          stat,
	output heq_pkg::heq_cmd_t           cmd
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_CNT_WR  = 3'd1;
	localparam logic [2:0] S_BLD_RD  = 3'd2;
	localparam logic [2:0] S_BLD_WR  = 3'd3;
	localparam logic [2:0] S_MAP_LD  = 3'd4;
	localparam logic [2:0] S_MAP_DIV = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	assign item_stall = state_q != S_IDLE;

	// next state and datapath commands
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.addr_sel = heq_pkg::ADDR_IN;
				if (item_valid) begin
					cmd.pix_load = 1'b1;
					case (action)
						heq_pkg::ACT_CLEAR: begin
							cmd.clear = 1'b1;
						end
						heq_pkg::ACT_COUNT: begin
							if (!stat.total_full) begin
								cmd.rd_en = 1'b1;
								state_nxt = S_CNT_WR;
							end
						end
						heq_pkg::ACT_BUILD: begin
							cmd.acc_clr = 1'b1;
							cmd.idx_clr = 1'b1;
							state_nxt   = S_BLD_RD;
						end
						heq_pkg::ACT_MAP: begin
							cmd.rd_en = 1'b1;
							state_nxt = S_MAP_LD;
						end
						default: begin
							state_nxt = S_IDLE;
						end
					endcase
				end
			end
			S_CNT_WR: begin
				cmd.addr_sel  = heq_pkg::ADDR_PIX;
				cmd.wr_en     = 1'b1;
				cmd.total_inc = 1'b1;
				state_nxt     = S_IDLE;
			end
			S_BLD_RD: begin
				cmd.addr_sel = heq_pkg::ADDR_IDX;
				cmd.rd_en    = 1'b1;
				state_nxt    = S_BLD_WR;
			end
			S_BLD_WR: begin
				cmd.addr_sel = heq_pkg::ADDR_IDX;
				cmd.wr_en    = 1'b1;
				cmd.wr_acc   = 1'b1;
				cmd.acc_load = 1'b1;
				cmd.idx_inc  = 1'b1;
				state_nxt    = stat.idx_last ? S_IDLE : S_BLD_RD;
			end
			S_MAP_LD: begin
				cmd.addr_sel = heq_pkg::ADDR_PIX;
				if (stat.total_zero) begin
					// empty histogram maps to zero
					if (stat.out_free) begin
						cmd.out_load = 1'b1;
						cmd.out_zero = 1'b1;
						state_nxt    = S_IDLE;
					end
				end else begin
					cmd.div_start = 1'b1;
					state_nxt     = S_MAP_DIV;
				end
			end
			S_MAP_DIV: begin
				cmd.addr_sel = heq_pkg::ADDR_PIX;
				if (!stat.div_busy && stat.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

`ifndef ASSERT_OFF
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("result loaded over a waiting beat");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !stat.total_zero)
		else $error("divide started with zero total");
	a_sweep_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BLD_WR) && stat.idx_last |=> state_q == S_IDLE)
		else $error("cumulative sweep ran past last bin");
	a_count_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) && item_valid && (action == heq_pkg::ACT_COUNT)
		&& !stat.total_full |=> state_q == S_CNT_WR)
		else $error("count beat not followed by bin write");
`endif

endmodule

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for histogram_equalization_unit, with a beat driver,
// a result monitor and a bit-exact equalization predictor. Depends on heq_pkg and
// the unit's RTL.
`timescale 1ns / 100ps

module tb_top;

	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 7;
	localparam int RANDOM_OPS   = 2000;
	localparam int HOLD_CYCLES  = 3000;
	localparam int DRAIN_CYCLES = 600;
	localparam int QUEUE_DEPTH  = 1024;
	localparam int MAX_REPORTS  = 50;
	localparam int CYCLE_LIMIT  = 12_000_000;

	typedef logic [heq_pkg::ACT_W-1:0] act_t;
	typedef logic [heq_pkg::PIX_W-1:0] pix_t;
	typedef logic [heq_pkg::BIN_W-1:0] bin_t;

	typedef struct packed {
		act_t act;
		pix_t pix;
	} pixel_op_t;

	logic clk;
	logic arst_n       = 1'b0;
	logic item_valid   = 1'b0;
	logic item_stall;
	act_t action       = heq_pkg::ACT_CLEAR;
	pix_t pixel        = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	pix_t out_pixel;

	// predictor state: one bin per gray level and the frame's pixel count
	bin_t hist_bins [heq_pkg::NUM_BINS];
	bin_t frame_total;

	pixel_op_t pending_ops[$];
	pix_t      expected_pixels[$];

	int  ops_queued   = 0;
	int  ops_accepted = 0;
	int  mismatches   = 0;
	int  cycle_count  = 0;
	bit  beat_taken   = 1'b0;
	bit  hold_req     = 1'b0;
	int  hold_left    = HOLD_CYCLES;
	int  burst_left   = 1;
	int  gap_left     = 0;
	int  seg_left     = 0;
	int  seg_kind     = 0;
	pixel_op_t next_op;
	pix_t      want_pixel;

	histogram_equalization_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.action       (action),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_pixel    (out_pixel)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// saturate a bin value at the frame limit
	function automatic bin_t clip_bin(input longint unsigned v);
		if (v > longint'(heq_pkg::MAX_PIXELS))
			return heq_pkg::MAX_PIXELS;
		return v[heq_pkg::BIN_W-1:0];
	endfunction

	// round(cdf * 255 / total), ties to even, saturated to 255, zero for an empty frame
	function automatic pix_t equalize(input bin_t cdf, input bin_t total);
		longint unsigned num;
		longint unsigned quo;
		longint unsigned rem;
		if (total == '0)
			return '0;
		num = 64'(cdf) * 64'd255;
		quo = num / 64'(total);
		rem = num % 64'(total);
		if (2 * rem > 64'(total) || (2 * rem == 64'(total) && quo[0]))
			quo++;
		if (quo > 64'(heq_pkg::OUT_MAX))
			return heq_pkg::OUT_MAX;
		return quo[heq_pkg::PIX_W-1:0];
	endfunction

	// advance the predicted histogram by one accepted beat
	task automatic apply_op(input act_t act, input pix_t pix);
		longint unsigned acc;
		case (act)
			heq_pkg::ACT_CLEAR: begin
				foreach (hist_bins[i])
					hist_bins[i] = '0;
				frame_total = '0;
			end
			heq_pkg::ACT_COUNT: begin
				if (frame_total < heq_pkg::MAX_PIXELS) begin
					hist_bins[pix] = clip_bin(64'(hist_bins[pix]) + 1);
					frame_total    = frame_total + 1'b1;
				end
			end
			heq_pkg::ACT_BUILD: begin
				acc = 0;
				foreach (hist_bins[i]) begin
					acc          = 64'(clip_bin(acc + 64'(hist_bins[i])));
					hist_bins[i] = acc[heq_pkg::BIN_W-1:0];
				end
			end
			heq_pkg::ACT_MAP: begin
				expected_pixels.push_back(equalize(hist_bins[pix], frame_total));
			end
			default: begin
			end
		endcase
	endtask

	// append a beat, keeping the pending queue bounded
	task automatic queue_op(input act_t act, input pix_t pix);
		pixel_op_t op;
		while (pending_ops.size() >= QUEUE_DEPTH)
			@(posedge clk);
		op.act = act;
		op.pix = pix;
		pending_ops.push_back(op);
		ops_queued++;
	endtask

	// one random frame: clear (mostly), count in a gray window, build, map, with some noise
	task automatic run_frame();
		pix_t lo;
		int   span;
		int   n_counts;
		int   n_builds;
		int   n_maps;
		int   pick;
		if ($urandom_range(0, 9) != 0)
			queue_op(heq_pkg::ACT_CLEAR, pix_t'($urandom));
		lo   = pix_t'($urandom);
		span = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 15);
		n_counts = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 40);
		for (int i = 0; i < n_counts; i++) begin
			if ($urandom_range(0, 19) == 0)
				queue_op(act_t'($urandom), pix_t'($urandom));
			else
				queue_op(heq_pkg::ACT_COUNT, lo + pix_t'($urandom_range(0, span)));
		end
		pick     = $urandom_range(0, 9);
		n_builds = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(2, 5) : 1;
		for (int i = 0; i < n_builds; i++)
			queue_op(heq_pkg::ACT_BUILD, pix_t'($urandom));
		// counting on top of a built table
		if ($urandom_range(0, 7) == 0) begin
			for (int i = 0; i < $urandom_range(1, 3); i++)
				queue_op(heq_pkg::ACT_COUNT, lo + pix_t'($urandom_range(0, span)));
		end
		n_maps = $urandom_range(4, 20);
		for (int i = 0; i < n_maps; i++) begin
			if ($urandom_range(0, 3) == 0)
				queue_op(heq_pkg::ACT_MAP, pix_t'($urandom));
			else
				queue_op(heq_pkg::ACT_MAP, lo + pix_t'($urandom_range(0, span)));
		end
	endtask

	// beat driver: bursts with gaps, payload held while stalled
	always @(negedge clk) begin
		if (item_valid && !beat_taken) begin
			// stalled, hold the beat
		end else if (gap_left != 0) begin
			item_valid <= 1'b0;
			gap_left   = gap_left - 1;
		end else if (pending_ops.size() != 0) begin
			next_op    = pending_ops.pop_front();
			item_valid <= 1'b1;
			action     <= next_op.act;
			pixel      <= next_op.pix;
			burst_left = burst_left - 1;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 40);
				gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end
		end else begin
			item_valid <= 1'b0;
		end
	end

	// result stall: one long hold-off on request, then segments of varying pressure
	always @(negedge clk) begin
		if (hold_req && hold_left != 0) begin
			result_stall <= 1'b1;
			hold_left    = hold_left - 1;
		end else begin
			if (seg_left == 0) begin
				seg_kind = $urandom_range(0, 2);
				seg_left = $urandom_range(20, 200);
			end else begin
				seg_left = seg_left - 1;
			end
			case (seg_kind)
				0:       result_stall <= 1'b0;
				1:       result_stall <= ($urandom_range(0, 3) == 0);
				default: result_stall <= ($urandom_range(0, 1) == 1);
			endcase
		end
	end

	// monitor: check result beats first, then predict from the accepted input beat
	always @(posedge clk) begin
		beat_taken = 1'b0;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_pixels.size() == 0) begin
					if (mismatches < MAX_REPORTS)
						$display("%0t: out_pixel expected none actual %0d", $time, out_pixel);
					mismatches++;
				end else begin
					want_pixel = expected_pixels.pop_front();
					if (out_pixel !== want_pixel) begin
						if (mismatches < MAX_REPORTS)
							$display("%0t: out_pixel expected %0d actual %0d",
								 $time, want_pixel, out_pixel);
						mismatches++;
					end
				end
			end
			if (item_valid && !item_stall) begin
				beat_taken = 1'b1;
				ops_accepted++;
				apply_op(action, pixel);
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		foreach (hist_bins[i])
			hist_bins[i] = '0;
		frame_total = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty histogram, extreme pixels, ties, map before build
		queue_op(heq_pkg::ACT_MAP, 8'h00);
		queue_op(heq_pkg::ACT_COUNT, 8'h00);
		queue_op(heq_pkg::ACT_COUNT, 8'hFF);
		queue_op(heq_pkg::ACT_COUNT, 8'h55);
		queue_op(heq_pkg::ACT_COUNT, 8'hAA);
		queue_op(heq_pkg::ACT_MAP, 8'hAA);
		queue_op(heq_pkg::ACT_BUILD, 8'h00);
		queue_op(heq_pkg::ACT_MAP, 8'h55);
		queue_op(heq_pkg::ACT_MAP, 8'hFF);
		// tie that stays even: cdf 1 of total 6
		queue_op(heq_pkg::ACT_CLEAR, 8'hFF);
		queue_op(heq_pkg::ACT_COUNT, 8'h00);
		for (int i = 0; i < 5; i++)
			queue_op(heq_pkg::ACT_COUNT, 8'd200);
		queue_op(heq_pkg::ACT_BUILD, 8'hFF);
		queue_op(heq_pkg::ACT_MAP, 8'h00);
		queue_op(heq_pkg::ACT_MAP, 8'd200);
		// repeated builds drive the bins into saturation and the quotient past 255
		for (int i = 0; i < 3; i++)
			queue_op(heq_pkg::ACT_BUILD, 8'h00);
		queue_op(heq_pkg::ACT_COUNT, 8'hFF);
		queue_op(heq_pkg::ACT_MAP, 8'h00);
		queue_op(heq_pkg::ACT_MAP, 8'hFF);

		// random frames; the receiver backs off for a long stretch at the start
		hold_req = 1'b1;
		begin
			int first_op;
			first_op = ops_queued;
			while (ops_queued - first_op < RANDOM_OPS)
				run_frame();
		end

		while (ops_accepted != ops_queued)
			@(posedge clk);
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
